/* sv/bbz_pkg.sv */
// ----------------------------------------------------------------------------
// bbz_pkg
// Shared constants, types and codes of the zero-padded box blur.
// ----------------------------------------------------------------------------
package bbz_pkg;

  localparam int unsigned MAX_HEIGHT = 64;
  localparam int unsigned MAX_WIDTH  = 64;
  localparam int unsigned MAX_KERNEL = 9;
  localparam int unsigned DEPTH      = MAX_HEIGHT * MAX_WIDTH;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned DIM_W   = 7;
  localparam int unsigned KER_W   = 4;
  localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT);
  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned RAD_W   = $clog2((MAX_KERNEL - 1) / 2 + 1);
  localparam int unsigned KOFF_W  = RAD_W + 1;
  localparam int unsigned POS_W   = DIM_W + 1;
  localparam int unsigned SUM_W   = $clog2(MAX_KERNEL * MAX_KERNEL * ((1 << PIX_W) - 1) + 1);
  localparam int unsigned DIV_W   = SUM_W + 1;
  localparam int unsigned DVS_W   = $clog2(2 * MAX_KERNEL * MAX_KERNEL + 1);
  localparam int unsigned DCNT_W  = $clog2(DIV_W + 1);
  localparam int unsigned PROD_W  = 2 * KER_W;

  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = DIM_W;

  localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_KERNEL_HEIGHT = 2'd2;
  localparam logic [CFG_AW-1:0] REG_KERNEL_WIDTH  = 2'd3;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_SUM,
    ST_MEAN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] w;
    logic [RAD_W-1:0] rh;
    logic [RAD_W-1:0] rw;
  } win_t;

endpackage

/* sv/bbz_if.sv */
// ----------------------------------------------------------------------------
// bbz_if
// Valid/ready channel interfaces: input items, result items, register writes.
// ----------------------------------------------------------------------------
interface bbz_in_if;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [bbz_pkg::PIX_W-1:0] pixel_in;
  modport source (output valid, output func, output pixel_in, input ready);
  modport sink   (input valid, input func, input pixel_in, output ready);
endinterface

interface bbz_out_if;
  logic                     valid;
  logic                     ready;
  logic [bbz_pkg::PIX_W-1:0] blurred;
  logic                     last;
  modport source (output valid, output blurred, output last, input ready);
  modport sink   (input valid, input blurred, input last, output ready);
endinterface

interface bbz_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bbz_pkg::CFG_AW-1:0] addr;
  logic [bbz_pkg::CFG_DW-1:0] data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

/* sv/bbz_ram.sv */
// ----------------------------------------------------------------------------
// bbz_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bbz_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/bbz_div.sv */
// ----------------------------------------------------------------------------
// bbz_div
// Restoring divider, one quotient bit per cycle; shared by the raster
// position split and the rounded mean.
// ----------------------------------------------------------------------------
module bbz_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bbz_pkg::DIV_W-1:0] dividend_i,
  input  logic [bbz_pkg::DVS_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [bbz_pkg::DIV_W-1:0] quot_o,
  output logic [bbz_pkg::DVS_W-1:0] rem_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [bbz_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic [bbz_pkg::DIV_W-1:0]  dvd_q, dvd_d;
  logic [bbz_pkg::DVS_W-1:0]  dvs_q, dvs_d;
  logic [bbz_pkg::DVS_W-1:0]  rem_q, rem_d;
  logic [bbz_pkg::DVS_W:0]    rem_sh;
  logic                       qbit;

  always_comb begin
    rem_sh = {rem_q, dvd_q[bbz_pkg::DIV_W-1]};
    qbit   = (rem_sh >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = qbit ? bbz_pkg::DVS_W'(rem_sh - {1'b0, dvs_q})
                   : rem_sh[bbz_pkg::DVS_W-1:0];
      dvd_d = {dvd_q[bbz_pkg::DIV_W-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == bbz_pkg::DCNT_W'(bbz_pkg::DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

/* sv/bbz_win.sv */
// ----------------------------------------------------------------------------
// bbz_win
// Window sequencer: walks the kernel offsets, issues one frame memory read
// per in-frame tap and accumulates the returned pixels.
// ----------------------------------------------------------------------------
module bbz_win (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  bbz_pkg::win_t              win_i,
  output logic                       re_o,
  output logic [bbz_pkg::ADDR_W-1:0] raddr_o,
  input  logic [bbz_pkg::PIX_W-1:0]  rdata_i,
  output logic                       done_o,
  output logic [bbz_pkg::SUM_W-1:0]  sum_o
);

  localparam int unsigned FULL_W = bbz_pkg::ADDR_W + 1;

  bbz_pkg::win_t              win_q;
  logic                       busy_q, rvld_q, fin_q, done_q;
  logic [bbz_pkg::KOFF_W-1:0] i_q, j_q;
  logic [bbz_pkg::SUM_W-1:0]  sum_q;
  logic [bbz_pkg::POS_W-1:0]  r_pos, c_pos;
  logic                       r_ok, c_ok, last_it, tap_ok;
  logic [FULL_W-1:0]          addr_full;

  always_comb begin
    r_pos = bbz_pkg::POS_W'(win_q.row) + bbz_pkg::POS_W'(i_q) - bbz_pkg::POS_W'(win_q.rh);
    c_pos = bbz_pkg::POS_W'(win_q.col) + bbz_pkg::POS_W'(j_q) - bbz_pkg::POS_W'(win_q.rw);
    r_ok  = !r_pos[bbz_pkg::POS_W-1] && (r_pos < bbz_pkg::POS_W'(win_q.h));
    c_ok  = !c_pos[bbz_pkg::POS_W-1] && (c_pos < bbz_pkg::POS_W'(win_q.w));
    addr_full = FULL_W'(r_pos[bbz_pkg::ROW_W-1:0]) * FULL_W'(win_q.w)
              + FULL_W'(c_pos[bbz_pkg::COL_W-1:0]);
    last_it = (i_q == bbz_pkg::KOFF_W'({win_q.rh, 1'b0}))
           && (j_q == bbz_pkg::KOFF_W'({win_q.rw, 1'b0}));
    tap_ok  = busy_q && r_ok && c_ok;
  end

  assign re_o    = tap_ok;
  assign raddr_o = addr_full[bbz_pkg::ADDR_W-1:0];
  assign done_o  = done_q;
  assign sum_o   = sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rvld_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rvld_q <= tap_ok;
      fin_q  <= busy_q && last_it;
      done_q <= fin_q;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && last_it) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      win_q <= win_i;
      i_q   <= '0;
      j_q   <= '0;
      sum_q <= '0;
    end else begin
      if (busy_q) begin
        if (j_q == bbz_pkg::KOFF_W'({win_q.rw, 1'b0})) begin
          j_q <= '0;
          i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      if (rvld_q) begin
        sum_q <= sum_q + bbz_pkg::SUM_W'(rdata_i);
      end
    end
  end

endmodule

/* sv/box_blur_zero_padded.sv */
// ----------------------------------------------------------------------------
// box_blur_zero_padded
// Zero-padded mean blur over a frame held in an on-chip frame memory.
// ----------------------------------------------------------------------------
// Channels: in_i carries items (func 0 = load pixel_in at the next raster
// address, func 1 = compute the next output pixel); out_o returns blurred
// with last set on the final pixel of the frame; cfg_i writes image_height,
// image_width, kernel_height, kernel_width (index 0..3); the user must
// write them only while idle, as the block does not enforce this. A
// compute beat runs a position split (count / width) on the serial
// divider, starts the window, steps through N = (2*rh+1)*(2*rw+1) window
// positions (kh*kw for odd kernels) on the single read port of the frame
// memory, drains the pending reads, runs the rounded division, latches
// the mean and loads the output register; the next beat is taken once the
// result is in that register. A compute beat that has nothing to produce
// (frame not fully loaded, or frame already emitted) is taken and dropped
// with no result.
// Reset clears the counters and loads the register defaults 64, 64, 3, 3;
// the frame memory is not cleared and is never read before it is written.
// The result sits in an output register; a stalled receiver does not stop
// new beats, but a finished compute waits there until the register frees.
// ----------------------------------------------------------------------------
module box_blur_zero_padded (
  input  logic       clk_i,
  input  logic       rst_ni,
  bbz_in_if.sink     in_i,
  bbz_out_if.source  out_o,
  bbz_cfg_if.sink    cfg_i
);

  bbz_pkg::state_e state_q, state_d;

  logic [bbz_pkg::DIM_W-1:0] img_h_q, img_w_q;
  logic [bbz_pkg::KER_W-1:0] ker_h_q, ker_w_q;
  logic [bbz_pkg::DIM_W-1:0] h_cl, w_cl;
  logic [bbz_pkg::KER_W-1:0] kh_cl, kw_cl;
  logic [2*bbz_pkg::DIM_W-1:0] total_full;
  logic [bbz_pkg::CNT_W-1:0] total;
  logic [bbz_pkg::PROD_W-1:0] dprod;

  logic [bbz_pkg::CNT_W-1:0] load_q, load_d, emit_q, emit_d;
  logic in_acc, is_load, compute_ok, start_compute;
  logic ram_we;
  logic [bbz_pkg::ADDR_W-1:0] ram_waddr;

  logic div_start, div_sel_mean, div_done;
  logic [bbz_pkg::DIV_W-1:0] div_dvd, div_quot;
  logic [bbz_pkg::DVS_W-1:0] div_dvs, div_rem;

  logic win_start, win_done, win_re;
  logic [bbz_pkg::ADDR_W-1:0] win_raddr;
  logic [bbz_pkg::PIX_W-1:0] ram_rdata;
  logic [bbz_pkg::SUM_W-1:0] win_sum;
  bbz_pkg::win_t win_cfg;

  logic [bbz_pkg::PIX_W-1:0] mean_q, mean_d;
  logic out_load;
  logic out_valid_q;
  logic [bbz_pkg::PIX_W-1:0] blurred_q;
  logic last_q;

  // register clamping
  always_comb begin
    h_cl = (img_h_q == '0) ? bbz_pkg::DIM_W'(1)
         : (img_h_q > bbz_pkg::DIM_W'(bbz_pkg::MAX_HEIGHT)) ? bbz_pkg::DIM_W'(bbz_pkg::MAX_HEIGHT)
         : img_h_q;
    w_cl = (img_w_q == '0) ? bbz_pkg::DIM_W'(1)
         : (img_w_q > bbz_pkg::DIM_W'(bbz_pkg::MAX_WIDTH)) ? bbz_pkg::DIM_W'(bbz_pkg::MAX_WIDTH)
         : img_w_q;
    kh_cl = (ker_h_q == '0) ? bbz_pkg::KER_W'(1)
          : (ker_h_q > bbz_pkg::KER_W'(bbz_pkg::MAX_KERNEL)) ? bbz_pkg::KER_W'(bbz_pkg::MAX_KERNEL)
          : ker_h_q;
    kw_cl = (ker_w_q == '0) ? bbz_pkg::KER_W'(1)
          : (ker_w_q > bbz_pkg::KER_W'(bbz_pkg::MAX_KERNEL)) ? bbz_pkg::KER_W'(bbz_pkg::MAX_KERNEL)
          : ker_w_q;
    total_full = (2*bbz_pkg::DIM_W)'(h_cl) * (2*bbz_pkg::DIM_W)'(w_cl);
    total      = total_full[bbz_pkg::CNT_W-1:0];
    dprod      = bbz_pkg::PROD_W'(kh_cl) * bbz_pkg::PROD_W'(kw_cl);
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_h_q <= bbz_pkg::DIM_W'(64);
      img_w_q <= bbz_pkg::DIM_W'(64);
      ker_h_q <= bbz_pkg::KER_W'(3);
      ker_w_q <= bbz_pkg::KER_W'(3);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        bbz_pkg::REG_IMAGE_HEIGHT:  img_h_q <= cfg_i.data;
        bbz_pkg::REG_IMAGE_WIDTH:   img_w_q <= cfg_i.data;
        bbz_pkg::REG_KERNEL_HEIGHT: ker_h_q <= cfg_i.data[bbz_pkg::KER_W-1:0];
        bbz_pkg::REG_KERNEL_WIDTH:  ker_w_q <= cfg_i.data[bbz_pkg::KER_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc        = in_i.valid && in_i.ready;
  assign is_load       = (in_i.func == bbz_pkg::FUNC_LOAD);
  assign compute_ok    = (load_q >= total) && (emit_q < total);
  assign start_compute = in_acc && (in_i.func == bbz_pkg::FUNC_COMPUTE) && compute_ok;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbz_pkg::ST_IDLE: if (start_compute) state_d = bbz_pkg::ST_POS;
      bbz_pkg::ST_POS:  if (div_done) state_d = bbz_pkg::ST_SUM;
      bbz_pkg::ST_SUM:  if (win_done) state_d = bbz_pkg::ST_MEAN;
      bbz_pkg::ST_MEAN: if (div_done) state_d = bbz_pkg::ST_OUT;
      bbz_pkg::ST_OUT:  if (!out_valid_q || out_o.ready) state_d = bbz_pkg::ST_IDLE;
      default:          state_d = bbz_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_i.ready   = 1'b0;
    div_start    = 1'b0;
    div_sel_mean = 1'b0;
    win_start    = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      bbz_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        div_start  = start_compute;
      end
      bbz_pkg::ST_POS:  win_start = div_done;
      bbz_pkg::ST_SUM: begin
        div_start    = win_done;
        div_sel_mean = 1'b1;
      end
      bbz_pkg::ST_MEAN: ;
      bbz_pkg::ST_OUT:  out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  // counters and frame writes
  always_comb begin
    load_d    = load_q;
    emit_d    = emit_q;
    ram_we    = 1'b0;
    ram_waddr = load_q[bbz_pkg::ADDR_W-1:0];
    if (in_acc && is_load) begin
      ram_we = 1'b1;
      if (load_q >= total) begin
        ram_waddr = '0;
        load_d    = bbz_pkg::CNT_W'(1);
        emit_d    = '0;
      end else begin
        load_d = load_q + 1'b1;
      end
    end else if (out_load) begin
      emit_d = emit_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbz_pkg::ST_IDLE;
      load_q      <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      load_q  <= load_d;
      emit_q  <= emit_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  bbz_ram #(
    .WIDTH (bbz_pkg::PIX_W),
    .DEPTH (bbz_pkg::DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.pixel_in),
    .re_i    (win_re),
    .raddr_i (win_raddr),
    .rdata_o (ram_rdata)
  );

  // divider operands: raster split, then (2*sum + d) / (2*d)
  always_comb begin
    if (div_sel_mean) begin
      div_dvd = {win_sum, 1'b0} + bbz_pkg::DIV_W'(dprod);
      div_dvs = bbz_pkg::DVS_W'({dprod, 1'b0});
    end else begin
      div_dvd = bbz_pkg::DIV_W'(emit_q);
      div_dvs = bbz_pkg::DVS_W'(w_cl);
    end
  end

  bbz_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    win_cfg.row = div_quot[bbz_pkg::ROW_W-1:0];
    win_cfg.col = div_rem[bbz_pkg::COL_W-1:0];
    win_cfg.h   = h_cl;
    win_cfg.w   = w_cl;
    win_cfg.rh  = bbz_pkg::RAD_W'((kh_cl - 1'b1) >> 1);
    win_cfg.rw  = bbz_pkg::RAD_W'((kw_cl - 1'b1) >> 1);
  end

  bbz_win u_win (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (win_start),
    .win_i   (win_cfg),
    .re_o    (win_re),
    .raddr_o (win_raddr),
    .rdata_i (ram_rdata),
    .done_o  (win_done),
    .sum_o   (win_sum)
  );

  assign mean_d = (div_quot[bbz_pkg::DIV_W-1:bbz_pkg::PIX_W] != '0) ? '1
                : div_quot[bbz_pkg::PIX_W-1:0];

  always_ff @(posedge clk_i) begin
    if ((state_q == bbz_pkg::ST_MEAN) && div_done) begin
      mean_q <= mean_d;
    end
    if (out_load) begin
      blurred_q <= mean_q;
      last_q    <= ((emit_q + 1'b1) == total);
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.blurred = blurred_q;
  assign out_o.last    = last_q;

  a_emit_le_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q <= load_q)
    else $error("emit count ahead of load count");

  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_q <= bbz_pkg::CNT_W'(bbz_pkg::DEPTH))
    else $error("load count beyond frame memory");

  a_win_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_done |-> (state_q == bbz_pkg::ST_SUM))
    else $error("window sum finished outside sum phase");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == bbz_pkg::ST_POS || state_q == bbz_pkg::ST_MEAN))
    else $error("divider finished outside a divide phase");

  a_no_rd_wr_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_re |-> !ram_we)
    else $error("frame write during window read");

endmodule

/* test/tb_box_blur_zero_padded.sv */
// ----------------------------------------------------------------------------
// tb_box_blur_zero_padded
// Self-checking bench for the zero-padded box blur.
// ----------------------------------------------------------------------------
// Sends load and compute beats with random gaps and receiver stalls. A shadow
// frame memory plus the current register values give the expected blurred
// pixel for each compute beat that yields one; results are checked in order.
// Directed cases cover zero and tiny frames and kernels, oversize kernels and
// a register change inside a frame. A long receiver stall backs the block up.
// Random frames follow, mostly well-formed, with some broken sequences.
// ----------------------------------------------------------------------------
module tb_box_blur_zero_padded;

  localparam int unsigned SETTLE_CYCLES  = 150;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES    = 1500;

  typedef struct packed {
    logic [bbz_pkg::PIX_W-1:0] blurred;
    logic                      last;
  } blur_px_t;

  typedef enum int {FILL_RANDOM, FILL_WHITE, FILL_BLACK} fill_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bbz_in_if  in_if ();
  bbz_out_if out_if ();
  bbz_cfg_if cfg_if ();

  box_blur_zero_padded DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  blur_px_t                  pending_px[$];
  blur_px_t                  want_px;
  logic [bbz_pkg::PIX_W-1:0] shadow_frame [bbz_pkg::DEPTH];
  int                        loaded_px      = 0;
  int                        emitted_px     = 0;
  logic [bbz_pkg::DIM_W-1:0] rows_cfg       = bbz_pkg::DIM_W'(bbz_pkg::MAX_HEIGHT);
  logic [bbz_pkg::DIM_W-1:0] cols_cfg       = bbz_pkg::DIM_W'(bbz_pkg::MAX_WIDTH);
  logic [bbz_pkg::KER_W-1:0] kh_cfg         = bbz_pkg::KER_W'(3);
  logic [bbz_pkg::KER_W-1:0] kw_cfg         = bbz_pkg::KER_W'(3);
  int unsigned               send_gap_pct   = 7;
  int unsigned               recv_stall_pct = 53;
  int unsigned               hold_seq       = 0;
  int unsigned               sent_beats     = 0;
  int unsigned               err_count      = 0;
  int unsigned               idle_cycles    = 0;

  always #2 clk_i = ~clk_i;

  function automatic int clamp_dim(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int frame_size();
    return clamp_dim(rows_cfg, bbz_pkg::MAX_HEIGHT) * clamp_dim(cols_cfg, bbz_pkg::MAX_WIDTH);
  endfunction

  function automatic void predict_blur(input logic fn, input logic [bbz_pkg::PIX_W-1:0] pix);
    int rows, cols, total, kh, kw, d, acc, q, rh, rw, r0, c0, r, c;
    blur_px_t px;
    rows  = clamp_dim(rows_cfg, bbz_pkg::MAX_HEIGHT);
    cols  = clamp_dim(cols_cfg, bbz_pkg::MAX_WIDTH);
    total = rows * cols;
    if (fn == bbz_pkg::FUNC_LOAD) begin
      if (loaded_px >= total) begin
        loaded_px  = 0;
        emitted_px = 0;
      end
      if (loaded_px < bbz_pkg::DEPTH) shadow_frame[loaded_px] = pix;
      loaded_px++;
      return;
    end
    if (loaded_px < total || emitted_px >= total) return;
    kh  = clamp_dim(kh_cfg, bbz_pkg::MAX_KERNEL);
    kw  = clamp_dim(kw_cfg, bbz_pkg::MAX_KERNEL);
    d   = kh * kw;
    rh  = (kh - 1) / 2;
    rw  = (kw - 1) / 2;
    r0  = emitted_px / cols;
    c0  = emitted_px % cols;
    acc = 0;
    for (r = r0 - rh; r <= r0 + rh; r++)
      for (c = c0 - rw; c <= c0 + rw; c++)
        if (r >= 0 && r < rows && c >= 0 && c < cols) acc += shadow_frame[r * cols + c];
    q = (2 * acc + d) / (2 * d);
    if (q > 255) q = 255;
    emitted_px++;
    px = '{blurred: bbz_pkg::PIX_W'(q), last: (emitted_px == total)};
    pending_px.insert(pending_px.size(), px);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    err_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_px.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat blurred=%0d last=%0b",
                                  out_if.blurred, out_if.last));
      end else begin
        want_px = pending_px.pop_front();
        if (out_if.blurred !== want_px.blurred)
          report_mismatch($sformatf("blurred %0d, expected %0d",
                                    out_if.blurred, want_px.blurred));
        if (out_if.last !== want_px.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_if.last, want_px.last));
      end
    end
  end

  // receiver: random stalls, or a long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_beat(input logic fn, input logic [bbz_pkg::PIX_W-1:0] pix);
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.func     <= fn;
    in_if.pixel_in <= pix;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_blur(fn, pix);
    sent_beats++;
  endtask

  // wait for all results, then for the block to go idle
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bbz_pkg::CFG_AW-1:0] idx,
                           input logic [bbz_pkg::CFG_DW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    case (idx)
      bbz_pkg::REG_IMAGE_HEIGHT:  rows_cfg = val;
      bbz_pkg::REG_IMAGE_WIDTH:   cols_cfg = val;
      bbz_pkg::REG_KERNEL_HEIGHT: kh_cfg   = val[bbz_pkg::KER_W-1:0];
      bbz_pkg::REG_KERNEL_WIDTH:  kw_cfg   = val[bbz_pkg::KER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_frame(input logic [bbz_pkg::CFG_DW-1:0] rows,
                           input logic [bbz_pkg::CFG_DW-1:0] cols,
                           input logic [bbz_pkg::CFG_DW-1:0] kh,
                           input logic [bbz_pkg::CFG_DW-1:0] kw);
    settle();
    write_reg(bbz_pkg::REG_IMAGE_HEIGHT, rows);
    write_reg(bbz_pkg::REG_IMAGE_WIDTH, cols);
    write_reg(bbz_pkg::REG_KERNEL_HEIGHT, kh);
    write_reg(bbz_pkg::REG_KERNEL_WIDTH, kw);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_pixels(input int n, input fill_e fill);
    logic [bbz_pkg::PIX_W-1:0] pix;
    repeat (n) begin
      case (fill)
        FILL_WHITE: pix = '1;
        FILL_BLACK: pix = '0;
        default:    pix = bbz_pkg::PIX_W'($urandom_range(255));
      endcase
      send_beat(bbz_pkg::FUNC_LOAD, pix);
    end
  endtask

  task automatic compute_pixels(input int n);
    repeat (n) send_beat(bbz_pkg::FUNC_COMPUTE, bbz_pkg::PIX_W'($urandom_range(255)));
  endtask

  function automatic logic [bbz_pkg::CFG_DW-1:0] rand_dim();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) return bbz_pkg::CFG_DW'(bbz_pkg::MAX_HEIGHT);
    if (pick < 8) return bbz_pkg::CFG_DW'($urandom_range(bbz_pkg::MAX_HEIGHT, 127));
    return bbz_pkg::CFG_DW'($urandom_range(0, 8));
  endfunction

  function automatic logic [bbz_pkg::CFG_DW-1:0] rand_kernel();
    logic [bbz_pkg::CFG_DW-1:0] k;
    k = bbz_pkg::CFG_DW'($urandom_range(1, bbz_pkg::MAX_KERNEL));
    if ($urandom_range(99) < 15) k = bbz_pkg::CFG_DW'($urandom_range(0, 15));
    // upper data bits are dropped by the kernel registers
    if ($urandom_range(99) < 15)
      k[bbz_pkg::CFG_DW-1:bbz_pkg::KER_W] =
        (bbz_pkg::CFG_DW - bbz_pkg::KER_W)'($urandom_range(1, 7));
    return k;
  endfunction

  // one long edge at most, so frames stay short
  task automatic reconfigure();
    logic [bbz_pkg::CFG_DW-1:0] rows, cols;
    rows = rand_dim();
    cols = rand_dim();
    if (rows > 8) cols = bbz_pkg::CFG_DW'($urandom_range(0, 2));
    else if (cols > 8) rows = bbz_pkg::CFG_DW'($urandom_range(0, 2));
    set_frame(rows, cols, rand_kernel(), rand_kernel());
  endtask

  task automatic test_compute_before_load();
    compute_pixels(1);
  endtask

  task automatic test_shrink_mid_frame();
    load_pixels(6, FILL_RANDOM);
    set_frame(7'd2, 7'd2, 7'd3, 7'd3);
    compute_pixels(5);
  endtask

  task automatic test_single_pixel();
    set_frame(7'd0, 7'd0, 7'd0, 7'd0);
    load_pixels(1, FILL_WHITE);
    compute_pixels(2);
    load_pixels(1, FILL_BLACK);
    compute_pixels(1);
  endtask

  task automatic test_kernel_saturation();
    set_frame(7'd2, 7'd2, 7'h0F, 7'h1A);
    load_pixels(2, FILL_WHITE);
    compute_pixels(1);
    load_pixels(2, FILL_WHITE);
    compute_pixels(4);
  endtask

  task automatic test_output_backpressure();
    set_frame(7'd3, 7'd3, 7'd9, 7'd9);
    load_pixels(9, FILL_RANDOM);
    hold_seq++;
    compute_pixels(9);
  endtask

  task automatic test_random_frames(input int unsigned beats);
    int unsigned goal, pick;
    int          total;
    fill_e       fill;
    goal = sent_beats + beats;
    while (sent_beats < goal) begin
      if ($urandom_range(99) < 60) reconfigure();
      total = frame_size();
      pick  = $urandom_range(99);
      fill  = (pick < 10) ? FILL_WHITE : (pick < 15) ? FILL_BLACK : FILL_RANDOM;
      pick  = $urandom_range(99);
      if (pick < 75) begin
        load_pixels(total, fill);
        compute_pixels(total + (($urandom_range(3) == 0) ? 1 : 0));
      end else if (pick < 87) begin
        load_pixels(total, fill);
        compute_pixels($urandom_range(total));
        reconfigure();
        compute_pixels(frame_size());
      end else begin
        repeat (total + $urandom_range(total))
          send_beat(1'($urandom_range(1)), bbz_pkg::PIX_W'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    in_if.valid    <= 1'b0;
    in_if.func     <= bbz_pkg::FUNC_LOAD;
    in_if.pixel_in <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.addr    <= bbz_pkg::REG_IMAGE_HEIGHT;
    cfg_if.data    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_compute_before_load();
    test_shrink_mid_frame();
    test_single_pixel();
    test_kernel_saturation();
    test_output_backpressure();

    test_random_frames(600);
    send_gap_pct   = 53;
    recv_stall_pct = 7;
    test_random_frames(600);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_frames(600);

    settle();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
